// ===== rtl/mp3_frame_sync_finder_macros.svh =====
// ----------------------------------------------------------------------------
// mp3 frame sync finder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MP3_FRAME_SYNC_FINDER_MACROS_SVH
`define MP3_FRAME_SYNC_FINDER_MACROS_SVH

// same cycle implication
`define MFSF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mp3 frame sync finder check failed");

// next cycle implication
`define MFSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mp3 frame sync finder check failed");

`endif

// ===== rtl/mfsf_pkg.sv =====
// ----------------------------------------------------------------------------
// mfsf_pkg
// widths, header codes, job record and constant lookup tables
// ----------------------------------------------------------------------------
package mfsf_pkg;

   localparam int MAX_BUFFER  = 4096;
   localparam int POS_W       = $clog2(MAX_BUFFER + 1);
   localparam int OFF_W       = 12;
   localparam int DATA_W      = 8;
   localparam int BLEN_W      = 13;
   localparam int LEN_W       = 11;
   localparam int BPS_W       = 19;
   localparam int RATE_W      = 16;
   localparam int CH_W        = 2;
   localparam int VER_W       = 2;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int MIN_FRAME   = 24;
   localparam int FIRST_CAND  = 3;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [2:0] SYNC_TOP  = 3'b111;

   // version field codes in the header
   localparam logic [1:0] HDR_VER_25  = 2'b00;
   localparam logic [1:0] HDR_VER_RES = 2'b01;
   localparam logic [1:0] HDR_VER_2   = 2'b10;
   localparam logic [1:0] HDR_VER_1   = 2'b11;
   localparam logic [1:0] HDR_LAYER_3 = 2'b01;
   localparam logic [1:0] HDR_MODE_MONO = 2'b11;
   localparam logic [3:0] BRI_FREE    = 4'd0;
   localparam logic [3:0] BRI_BAD     = 4'd15;
   localparam logic [1:0] SRI_RES     = 2'd3;

   // reported version codes
   localparam logic [VER_W-1:0] VER_MPEG1  = 2'd0;
   localparam logic [VER_W-1:0] VER_MPEG2  = 2'd1;
   localparam logic [VER_W-1:0] VER_MPEG25 = 2'd2;

   localparam logic [CH_W-1:0] CH_MONO   = 2'd1;
   localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

   localparam int RATE_44K = 44100;
   localparam int RATE_48K = 48000;
   localparam int RATE_32K = 32000;
   localparam int MUL_V1   = 144000;
   localparam int MUL_V25  = 2 * 72000;
   localparam int MUL_V25X = 2 * MUL_V25;
   localparam int KBPS_MUL = 1000;

   localparam int KBPS_V1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                    224, 256, 320, 0};
   localparam int KBPS_V2 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
                                    128, 144, 160, 0};

   typedef logic [255:0][LEN_W-1:0]  len_tab_type;
   typedef logic [31:0][BPS_W-1:0]   bps_tab_type;
   typedef logic [15:0][RATE_W-1:0]  rate_tab_type;

   typedef struct packed {
      logic              first;
      logic              last;
      logic              cand;
      logic [1:0]        ver;
      logic [1:0]        sri;
      logic [3:0]        bri;
      logic              pad;
      logic              mono;
      logic [OFF_W-1:0]  off;
      logic [POS_W-1:0]  avail;
   } mfsf_job_type;

   // frame length without padding, indexed by version, rate index and bitrate index
   function automatic len_tab_type build_len_table();
      len_tab_type t;
      int ver;
      int sri;
      int bri;
      int k;
      int m;
      int q;
      for (int i = 0; i < 256; i++) begin
         ver = (i >> 6) & 3;
         sri = (i >> 4) & 3;
         bri = i & 15;
         k   = (ver == 3) ? KBPS_V1[bri] : KBPS_V2[bri];
         m   = (ver == 0) ? MUL_V25X : MUL_V1;
         case (sri)
            0:       q = (m * k) / RATE_44K;
            1:       q = (m * k) / RATE_48K;
            default: q = (m * k) / RATE_32K;
         endcase
         if (ver == 1 || sri == 3 || bri == 0 || bri == 15) begin
            t[i] = '0;
         end else begin
            t[i] = LEN_W'(q);
         end
      end
      return t;
   endfunction

   // bitrate in bit/s, indexed by mpeg1 flag and bitrate index
   function automatic bps_tab_type build_bps_table();
      bps_tab_type t;
      int k;
      for (int i = 0; i < 32; i++) begin
         k    = (i >= 16) ? KBPS_V1[i & 15] : KBPS_V2[i & 15];
         t[i] = BPS_W'(k * KBPS_MUL);
      end
      return t;
   endfunction

   // sample rate after version scaling, indexed by version and rate index
   function automatic rate_tab_type build_rate_table();
      rate_tab_type t;
      int ver;
      int sri;
      int r;
      for (int i = 0; i < 16; i++) begin
         ver = (i >> 2) & 3;
         sri = i & 3;
         case (sri)
            0:       r = RATE_44K;
            1:       r = RATE_48K;
            2:       r = RATE_32K;
            default: r = 0;
         endcase
         case (ver)
            3:       t[i] = RATE_W'(r);
            2:       t[i] = RATE_W'(r >> 1);
            0:       t[i] = RATE_W'(r >> 2);
            default: t[i] = '0;
         endcase
      end
      return t;
   endfunction

   localparam len_tab_type  LEN_TABLE  = build_len_table();
   localparam bps_tab_type  BPS_TABLE  = build_bps_table();
   localparam rate_tab_type RATE_TABLE = build_rate_table();

endpackage

// ===== rtl/mp3_frame_sync_finder.sv =====
// ----------------------------------------------------------------------------
// mp3_frame_sync_finder
// finds the first valid layer iii frame header in each byte buffer
// ----------------------------------------------------------------------------
//  channel  dir  handshake              contents
//  req_     in   req_tvalid/req_tready  one buffer byte, length, first and last marks
//  rsp_     out  rsp_tvalid/rsp_tready  one result per buffer, hit or not found
//
//  one byte a cycle while the four-entry job queue has room
//  the deciding byte's job passes through the queue and then the output register before the result shows
//  bytes that can never decide anything skip the queue
//  synchronous reset clears window, position, queue and result flag
//  a stalled result holds the evaluator while intake carries on until the queue fills
// ----------------------------------------------------------------------------
module mp3_frame_sync_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_byte [7:0], buffer_length [20:8], zero fill
   input  logic [mfsf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // first_byte
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // frame_offset [11:0], frame_length [22:12], bitrate_bps [41:23],
   // sample_rate [57:42], channel_count [59:58], mpeg_version [61:60], zero fill
   output logic [mfsf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // found
   output logic                              rsp_tuser
);
   import mfsf_pkg::*;

   mfsf_job_type  push_job;
   mfsf_job_type  head_job;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;

   mfsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   mfsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_job  (head_job)
   );

   mfsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/mfsf_front.sv =====
// ----------------------------------------------------------------------------
// mfsf_front
// byte intake: sliding window, position count and header pre-check
// ----------------------------------------------------------------------------
module mfsf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mfsf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   input  logic                              q_full,
   output logic                              q_push,
   output mfsf_pkg::mfsf_job_type            q_job
);
   import mfsf_pkg::*;

   logic [23:0]       window_ff, window_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  pos_cur;
   logic [POS_W-1:0]  eff;
   logic [BLEN_W-1:0] blen;
   logic [7:0]        b0, b1, b2, b3;
   logic              in_range;
   logic              hdr_ok;
   logic              accept;
   logic [POS_W-1:0]  off_full;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign b0   = window_ff[23:16];
   assign b1   = window_ff[15:8];
   assign b2   = window_ff[7:0];
   assign b3   = req_tdata[DATA_W-1:0];
   assign blen = req_tdata[DATA_W +: BLEN_W];

   assign pos_cur  = req_tuser ? '0 : pos_ff;
   assign eff      = (POS_W'(blen) < POS_W'(MAX_BUFFER)) ? POS_W'(blen) : POS_W'(MAX_BUFFER);
   assign in_range = (pos_cur >= POS_W'(FIRST_CAND)) && (pos_cur < eff);
   assign off_full = pos_cur - POS_W'(FIRST_CAND);

   assign hdr_ok = (b0 == SYNC_BYTE) && (b1[7:5] == SYNC_TOP) && (b1[4:3] != HDR_VER_RES)
                && (b1[2:1] == HDR_LAYER_3) && (b2[7:4] != BRI_FREE) && (b2[7:4] != BRI_BAD)
                && (b2[3:2] != SRI_RES);

   always_comb begin
      q_job.first = req_tuser;
      q_job.last  = req_tlast;
      q_job.cand  = in_range && hdr_ok;
      q_job.ver   = b1[4:3];
      q_job.sri   = b2[3:2];
      q_job.bri   = b2[7:4];
      q_job.pad   = b2[1];
      q_job.mono  = (b3[7:6] == HDR_MODE_MONO);
      q_job.off   = off_full[OFF_W-1:0];
      q_job.avail = eff - off_full;
   end

   assign q_push = accept && (req_tuser || req_tlast || q_job.cand);

   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      if (accept) begin
         window_in = {window_ff[15:0], b3};
         pos_in    = (pos_cur < POS_W'(MAX_BUFFER)) ? pos_cur + 1'b1 : pos_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

// ===== rtl/mfsf_queue.sv =====
// ----------------------------------------------------------------------------
// mfsf_queue
// short job queue between intake and evaluation
// ----------------------------------------------------------------------------
module mfsf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mfsf_pkg::mfsf_job_type  push_job,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output mfsf_pkg::mfsf_job_type  head_job
);
   import mfsf_pkg::*;

   mfsf_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_job  = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/mfsf_back.sv =====
// ----------------------------------------------------------------------------
// mfsf_back
// frame length check, per-buffer result selection and output register
// ----------------------------------------------------------------------------
module mfsf_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  mfsf_pkg::mfsf_job_type            q_job,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mfsf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser
);
   import mfsf_pkg::*;

   logic                    done_ff, done_in;
   logic                    valid_ff, valid_in;
   logic                    found_ff, found_in;
   logic [RSP_TDATA_W-1:0]  data_ff, data_in;
   logic                    done_cur;
   logic [LEN_W-1:0]        len;
   logic                    hit;
   logic                    emit;
   logic                    is_v1;
   logic [VER_W-1:0]        ver_code;
   logic [CH_W-1:0]         ch;

   assign q_pop = q_valid && (!valid_ff || rsp_tready);

   assign done_cur = q_job.first ? 1'b0 : done_ff;
   assign len      = LEN_TABLE[{q_job.ver, q_job.sri, q_job.bri}] + LEN_W'(q_job.pad);
   assign hit      = q_job.cand && (len >= LEN_W'(MIN_FRAME))
                  && (POS_W'(len) <= q_job.avail);
   assign emit     = !done_cur && (hit || q_job.last);
   assign is_v1    = (q_job.ver == HDR_VER_1);
   assign ch       = q_job.mono ? CH_MONO : CH_STEREO;

   always_comb begin
      unique case (q_job.ver)
         HDR_VER_1: ver_code = VER_MPEG1;
         HDR_VER_2: ver_code = VER_MPEG2;
         default:   ver_code = VER_MPEG25;
      endcase
   end

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff && !rsp_tready;
      found_in = found_ff;
      data_in  = data_ff;
      if (q_pop) begin
         done_in = done_cur || emit;
         if (emit) begin
            valid_in = 1'b1;
            found_in = hit;
            data_in  = '0;
            if (hit) begin
               data_in = {2'b00, ver_code, ch,
                          RATE_TABLE[{q_job.ver, q_job.sri}],
                          BPS_TABLE[{is_v1, q_job.bri}],
                          len, q_job.off};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
      found_ff <= found_in;
      data_ff  <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/mfsf_checker.sv =====
// ----------------------------------------------------------------------------
// mfsf_checker
// port level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "mp3_frame_sync_finder_macros.svh"

module mfsf_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [mfsf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              rsp_tuser
);
   import mfsf_pkg::*;

   logic [OFF_W-1:0]   rsp_off;
   logic [LEN_W-1:0]   rsp_len;
   logic [CH_W-1:0]    rsp_ch;
   logic [BLEN_W-1:0]  rsp_end;
   logic               hit_fits;

   assign rsp_off  = rsp_tdata[11:0];
   assign rsp_len  = rsp_tdata[22:12];
   assign rsp_ch   = rsp_tdata[59:58];
   assign rsp_end  = BLEN_W'(rsp_off) + BLEN_W'(rsp_len);
   assign hit_fits = (rsp_len >= LEN_W'(MIN_FRAME)) && (rsp_end <= BLEN_W'(MAX_BUFFER))
                  && (rsp_ch != '0);

   `MFSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   `MFSF_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

   `MFSF_ASSERT_NOW(a_hit_fits, clock, reset, rsp_tvalid && rsp_tuser, hit_fits)

   `MFSF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind mp3_frame_sync_finder mfsf_checker u_checker (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for mp3_frame_sync_finder
// drives byte buffers with and without layer iii headers through the stream
// port, predicts each buffer's result and compares every result word field
// by field, with random gaps, a long result stall and a drain pause
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mfsf_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      logic                found;
      logic [OFF_W-1:0]    offset;
      logic [LEN_W-1:0]    frame_len;
      logic [BPS_W-1:0]    bps;
      logic [RATE_W-1:0]   rate;
      logic [CH_W-1:0]     chans;
      logic [VER_W-1:0]    version;
   } sync_result_type;

   localparam int unsigned MPEG1_KBPS [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
                                               192, 224, 256, 320, 0};
   localparam int unsigned LSF_KBPS [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
                                             128, 144, 160, 0};
   localparam int unsigned BASE_HZ [4] = '{44100, 48000, 32000, 0};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;

   // scanner state as seen by the predictor
   logic [23:0]   hdr_window = '0;
   int unsigned   scan_pos = 0;
   bit            scan_closed = 1'b0;

   sync_result_type  sync_results_due[$];
   int unsigned   live_items = 0;
   int unsigned   fail_count = 0;
   int unsigned   hold_cycles = 0;
   bit            idling = 1'b1;

   mp3_frame_sync_finder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // header check on a four byte candidate with room bytes left from its start
   function automatic bit decode_header(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input int unsigned room, output sync_result_type r);
      logic [1:0]  ver;
      logic [1:0]  sri;
      logic [3:0]  bri;
      int unsigned kbps;
      int unsigned hz;
      int unsigned flen;
      r = '0;
      ver = b1[4:3];
      bri = b2[7:4];
      sri = b2[3:2];
      if (b0 != SYNC_BYTE || b1[7:5] != SYNC_TOP) return 1'b0;
      if (ver == HDR_VER_RES || b1[2:1] != HDR_LAYER_3) return 1'b0;
      if (bri == BRI_FREE || bri == BRI_BAD || sri == SRI_RES) return 1'b0;
      kbps = (ver == HDR_VER_1) ? MPEG1_KBPS[bri] : LSF_KBPS[bri];
      hz = BASE_HZ[sri];
      if (ver == HDR_VER_2) hz = hz / 2;
      if (ver == HDR_VER_25) hz = hz / 4;
      flen = (((ver == HDR_VER_1) ? 144000 : 72000) * kbps) / hz + b2[1];
      if (flen < 24 || flen > room) return 1'b0;
      r.frame_len = LEN_W'(flen);
      r.bps = BPS_W'(kbps * 1000);
      r.rate = RATE_W'(hz);
      r.chans = (b3[7:6] == HDR_MODE_MONO) ? CH_MONO : CH_STEREO;
      r.version = (ver == HDR_VER_1) ? VER_MPEG1 : ((ver == HDR_VER_2) ? VER_MPEG2 : VER_MPEG25);
      return 1'b1;
   endfunction

   // advances the scanner by one byte, returns 1 when the byte closes the buffer
   function automatic bit scan_byte(input logic [7:0] b, input logic [12:0] blen,
                                    input logic first, input logic last,
                                    output sync_result_type r);
      int unsigned eff;
      r = '0;
      if (first) begin
         scan_pos = 0;
         scan_closed = 1'b0;
      end
      if (scan_closed) return 1'b0;
      eff = (blen < MAX_BUFFER) ? blen : MAX_BUFFER;
      if (scan_pos >= 3 && scan_pos < eff) begin
         if (decode_header(hdr_window[23:16], hdr_window[15:8], hdr_window[7:0], b,
                           eff - (scan_pos - 3), r)) begin
            r.found = 1'b1;
            r.offset = OFF_W'(scan_pos - 3);
            scan_closed = 1'b1;
            hdr_window = {hdr_window[15:0], b};
            return 1'b1;
         end
      end
      hdr_window = {hdr_window[15:0], b};
      if (scan_pos < MAX_BUFFER) scan_pos++;
      if (last) begin
         r = '0;
         scan_closed = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (fail_count < 50) begin
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      fail_count++;
   endtask

   task automatic check_result();
      sync_result_type got;
      sync_result_type want;
      got.found = rsp_tuser;
      got.offset = rsp_tdata[11:0];
      got.frame_len = rsp_tdata[22:12];
      got.bps = rsp_tdata[41:23];
      got.rate = rsp_tdata[57:42];
      got.chans = rsp_tdata[59:58];
      got.version = rsp_tdata[61:60];
      if (sync_results_due.size() == 0) begin
         report_mismatch("unexpected result word", 1, 0);
         return;
      end
      want = sync_results_due.pop_front();
      if (got.found != want.found) report_mismatch("found", got.found, want.found);
      if (got.offset != want.offset) report_mismatch("frame_offset", got.offset, want.offset);
      if (got.frame_len != want.frame_len) begin
         report_mismatch("frame_length", got.frame_len, want.frame_len);
      end
      if (got.bps != want.bps) report_mismatch("bitrate_bps", got.bps, want.bps);
      if (got.rate != want.rate) report_mismatch("sample_rate", got.rate, want.rate);
      if (got.chans != want.chans) report_mismatch("channel_count", got.chans, want.chans);
      if (got.version != want.version) report_mismatch("mpeg_version", got.version, want.version);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
   end

   // result side: long hold-off first, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else if (idling && $urandom_range(99) < 31) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic [12:0] blen,
                            input logic first, input logic last);
      sync_result_type r;
      while (idling && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, blen, b};
      req_tuser <= first;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      live_items++;
      if (scan_byte(b, blen, first, last, r)) sync_results_due.push_back(r);
      @(negedge clock);
   endtask

   task automatic send_buffer(input byte_queue_type bytes, input logic [12:0] blen,
                              input bit with_first, input bit with_last);
      foreach (bytes[i]) begin
         send_byte(bytes[i], blen, with_first && i == 0, with_last && i == bytes.size() - 1);
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sync_results_due.size() != 0);
   endtask

   function automatic logic [31:0] random_header();
      logic [1:0] ver;
      case ($urandom_range(2))
         0:       ver = HDR_VER_1;
         1:       ver = HDR_VER_2;
         default: ver = HDR_VER_25;
      endcase
      return {SYNC_BYTE, SYNC_TOP, ver, HDR_LAYER_3, 1'($urandom),
              4'($urandom_range(14, 1)), 2'($urandom_range(2)), 1'($urandom), 1'($urandom),
              8'($urandom)};
   endfunction

   // spoils exactly one of the header checks
   function automatic logic [31:0] break_header(input logic [31:0] h);
      case ($urandom_range(5))
         0:       h[31:24] = 8'($urandom_range(254));
         1:       h[23:21] = 3'($urandom_range(6));
         2:       h[20:19] = HDR_VER_RES;
         3:       h[18:17] = HDR_LAYER_3 ^ 2'($urandom_range(3, 1));
         4:       h[15:12] = ($urandom_range(1) == 0) ? BRI_FREE : BRI_BAD;
         default: h[11:10] = SRI_RES;
      endcase
      return h;
   endfunction

   task automatic random_buffer();
      byte_queue_type bytes;
      int unsigned n;
      int unsigned kind;
      int unsigned at;
      logic [31:0] hdr;
      logic [12:0] blen;
      n = ($urandom_range(9) == 0) ? $urandom_range(300, 40) : $urandom_range(39, 1);
      for (int i = 0; i < n; i++) begin
         bytes.push_back(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
      end
      kind = $urandom_range(99);
      if (kind < 85 && n >= 4) begin
         hdr = random_header();
         if (kind >= 65) hdr = break_header(hdr);
         at = $urandom_range(n - 4);
         for (int k = 0; k < 4; k++) bytes[at + k] = hdr[31 - 8 * k -: 8];
      end
      case ($urandom_range(9))
         0, 1, 2, 3, 4: blen = 13'($urandom_range(4096, n));
         5, 6:          blen = 13'(n);
         7:             blen = 13'($urandom_range(8191));
         default:       blen = 13'($urandom_range(n));
      endcase
      send_buffer(bytes, blen, $urandom_range(19) != 0, $urandom_range(19) != 0);
   endtask

   // no first mark after reset, then bytes after the result are dropped
   task automatic test_stream_from_reset();
      byte_queue_type pkt;
      pkt = {8'hFF, 8'hFB, 8'h90, 8'h44, 8'h00, 8'h00};
      send_buffer(pkt, 13'd500, 1'b0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_header_cases();
      byte_queue_type pkt;
      // one byte buffer and a three byte buffer
      pkt = {8'h5A};
      send_buffer(pkt, 13'd1, 1'b1, 1'b1);
      pkt = {8'hFF, 8'hFB, 8'h90};
      send_buffer(pkt, 13'd3, 1'b1, 1'b1);
      // mpeg2 mono header completed by the last byte
      pkt = {8'h00, 8'hFF, 8'hF3, 8'h16, 8'hC0};
      send_buffer(pkt, 13'd30, 1'b1, 1'b1);
      // largest frame, exactly fitting and one byte short
      pkt = {8'hFF, 8'hFB, 8'hEA, 8'h00};
      send_buffer(pkt, 13'd1441, 1'b1, 1'b1);
      send_buffer(pkt, 13'd1440, 1'b1, 1'b1);
      // mpeg2.5 with a length beyond capacity
      pkt = {8'hFF, 8'hE3, 8'hE8, 8'h80};
      send_buffer(pkt, 13'd8191, 1'b1, 1'b1);
      // zero length, and a header outside the stated length
      pkt = {8'hFF, 8'hFB, 8'h90, 8'h44, 8'hFF};
      send_buffer(pkt, 13'd0, 1'b1, 1'b1);
      pkt = {8'h00, 8'h00, 8'hFF, 8'hFB, 8'h90, 8'h44};
      send_buffer(pkt, 13'd5, 1'b1, 1'b1);
      // reserved version, wrong layer, bitrate 0 and 15, rate 3, bad sync
      pkt = {8'hFF, 8'hEB, 8'h90, 8'hFF, 8'hFC, 8'h90, 8'hFF, 8'hFB, 8'h00, 8'hFF, 8'hFB,
             8'hF0, 8'hFF, 8'hFB, 8'h9C, 8'hFF, 8'hDB, 8'h90, 8'h00};
      send_buffer(pkt, 13'd4096, 1'b1, 1'b1);
      wait_for_results();
   endtask

   // results held back long enough for the job queue to fill and stall intake
   task automatic test_full_backpressure();
      byte_queue_type pkt;
      logic [31:0] hdr;
      idling = 1'b0;
      hold_cycles = 400;
      repeat (16) begin
         pkt = {};
         repeat ($urandom_range(2)) pkt.push_back(8'h00);
         hdr = random_header();
         for (int k = 0; k < 4; k++) pkt.push_back(hdr[31 - 8 * k -: 8]);
         repeat (3) pkt.push_back(8'($urandom));
         send_buffer(pkt, 13'd4000, 1'b1, 1'b1);
      end
      wait_for_results();
      idling = 1'b1;
   endtask

   // a header deep into a buffer whose stated length is beyond capacity
   task automatic test_position_limit();
      byte_queue_type pkt;
      repeat (300) pkt.push_back(8'h00);
      pkt = {pkt, 8'hFF, 8'hFB, 8'h90, 8'h44, 8'h00, 8'h00};
      send_buffer(pkt, 13'd8191, 1'b1, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_buffers();
      int unsigned stop_at;
      idling = 1'b0;
      stop_at = live_items + 150;
      while (live_items < stop_at) random_buffer();
      idling = 1'b1;
      stop_at = live_items + 350;
      while (live_items < stop_at) random_buffer();
      wait_for_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_stream_from_reset();
      test_header_cases();
      test_full_backpressure();
      test_position_limit();
      test_random_buffers();
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
